// ===== design/tmwf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmwf_pkg
// shared types, codes and side-rotation helpers of the triangle maze walker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmwf_pkg;

  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned STORE_AW    = 12;
  localparam int unsigned WALL_W      = 3;
  localparam int unsigned DIM_W       = 7;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned PROD_W      = 2 * DIM_W;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 7;

  // sides of a triangle, one-hot
  localparam logic [WALL_W-1:0] SIDE_LEFT  = 3'b001;
  localparam logic [WALL_W-1:0] SIDE_RIGHT = 3'b010;
  localparam logic [WALL_W-1:0] SIDE_HORIZ = 3'b100;
  localparam logic [WALL_W-1:0] SIDE_NONE  = 3'b000;
  localparam logic [WALL_W-1:0] WALLS_ALL  = 3'b111;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_ENCLOSED = 2'd2,
    ST_IDLE     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAZE_ROWS = 3'd0,
    CFG_MAZE_COLS = 3'd1,
    CFG_START_ROW = 3'd2,
    CFG_START_COL = 3'd3,
    CFG_HAND_RULE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0] maze_rows;
    logic [DIM_W-1:0] maze_cols;
    logic [POS_W-1:0] start_row;
    logic [POS_W-1:0] start_col;
    logic             hand_rule;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic wr;
    logic rd;
    logic eval;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
  } stat_t;

  // zero counts as one, anything above the maximum is clipped
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, int unsigned max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > int'(max_v)) begin
      r = DIM_W'(max_v);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [WALL_W-1:0] turn_side(logic [WALL_W-1:0] side, logic up,
                                                   logic lh);
    logic [WALL_W-1:0] r;
    if (up == lh) begin
      r = (side == SIDE_HORIZ) ? SIDE_LEFT : {side[WALL_W-2:0], 1'b0};
    end else begin
      r = (side == SIDE_LEFT) ? SIDE_HORIZ : {1'b0, side[WALL_W-1:1]};
    end
    return r;
  endfunction

  function automatic logic [WALL_W-1:0] side_on_entry(logic [WALL_W-1:0] dir, logic up,
                                                       logic lh);
    logic [WALL_W-1:0] r;
    if (!lh) begin
      if (dir == SIDE_RIGHT)     r = up ? SIDE_HORIZ : SIDE_RIGHT;
      else if (dir == SIDE_LEFT) r = up ? SIDE_LEFT : SIDE_HORIZ;
      else                       r = up ? SIDE_RIGHT : SIDE_LEFT;
    end else begin
      if (dir == SIDE_RIGHT)     r = up ? SIDE_RIGHT : SIDE_HORIZ;
      else if (dir == SIDE_LEFT) r = up ? SIDE_HORIZ : SIDE_LEFT;
      else                       r = up ? SIDE_LEFT : SIDE_RIGHT;
    end
    return r;
  endfunction

  // first held side at the entry cell, SIDE_NONE when blocked
  function automatic logic [WALL_W-1:0] pick_entry(logic [DIM_W-1:0] r, logic [DIM_W-1:0] c,
                                                    logic [DIM_W-1:0] rows,
                                                    logic [DIM_W-1:0] cols,
                                                    logic [WALL_W-1:0] w, logic lh);
    logic [WALL_W-1:0] s;
    if (c == '0 && (w & SIDE_LEFT) == '0) begin
      if (r[0]) s = lh ? SIDE_RIGHT : SIDE_HORIZ;
      else      s = lh ? SIDE_HORIZ : SIDE_RIGHT;
    end else if (c == cols - DIM_W'(1) && (w & SIDE_RIGHT) == '0) begin
      if (r[0] ^ c[0]) s = lh ? SIDE_HORIZ : SIDE_LEFT;
      else             s = lh ? SIDE_LEFT : SIDE_HORIZ;
    end else if (r == rows - DIM_W'(1) && (w & SIDE_HORIZ) == '0) begin
      s = lh ? SIDE_LEFT : SIDE_RIGHT;
    end else if (r == '0 && (w & SIDE_HORIZ) == '0) begin
      s = lh ? SIDE_RIGHT : SIDE_LEFT;
    end else begin
      s = SIDE_NONE;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== design/tmwf_ram.sv =====
// ----------------------------------------------------------------------------
// tmwf_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmwf_ram #(
  parameter int unsigned WIDTH = 3,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/tmwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmwf_ctrl
// sequencer: capture, address multiply, store read, evaluate and hand off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmwf_ctrl import tmwf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_RD,
    S_EVAL
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        unique case (stat_i.op) inside
          OP_WRITE: begin
            cmd_o.wr = 1'b1;
            state_d  = S_IDLE;
          end
          OP_START, OP_STEP: begin
            state_d = S_RD;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        if (out_free) begin
          cmd_o.eval  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/tmwf_datapath.sv =====
// ----------------------------------------------------------------------------
// tmwf_datapath
// walk state, wall store, address multiply and step evaluation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmwf_datapath import tmwf_pkg::*; #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire cmd_t                cmd_i,
  output stat_t                    stat_o,
  input  wire logic [1:0]          op_i,
  input  wire logic [STORE_AW-1:0] cell_index_i,
  input  wire logic [WALL_W-1:0]   wall_mask_i,
  output logic      [POS_W-1:0]    cell_row_o,
  output logic      [POS_W-1:0]    cell_col_o,
  output logic                     exited_o,
  output logic      [1:0]          status_o
);

  // captured item
  logic [1:0]          op_q;
  logic [STORE_AW-1:0] idx_q;
  logic [WALL_W-1:0]   mask_q;

  // walk state
  logic [DIM_W-1:0]  walk_row_q, walk_row_d;
  logic [DIM_W-1:0]  walk_col_q, walk_col_d;
  logic [WALL_W-1:0] held_q, held_d;
  logic              walking_q, walking_d;

  logic [PROD_W-1:0] prod_q;

  // result register
  logic [POS_W-1:0] row_res_q, row_res_d;
  logic [POS_W-1:0] col_res_q, col_res_d;
  logic             exit_res_q, exit_res_d;
  logic [1:0]       stat_res_q, stat_res_d;

  logic [DIM_W-1:0]    rows, cols;
  logic                lh;
  logic [DIM_W-1:0]    row_src, col_src;
  logic [PROD_W:0]     addr_sum;
  logic [WALL_W-1:0]   walls;
  logic [WALL_W-1:0]   entry;
  logic                start_in;
  logic                up;
  logic [WALL_W-1:0]   b1, b2;
  logic [DIM_W:0]      nxt_row, nxt_col;
  logic                leaves;

  assign rows = eff_dim(cfg_i.maze_rows, MAX_ROWS);
  assign cols = eff_dim(cfg_i.maze_cols, MAX_COLS);
  assign lh   = cfg_i.hand_rule;

  assign row_src = (op_q == OP_START) ? {1'b0, cfg_i.start_row} : walk_row_q;
  assign col_src = (op_q == OP_START) ? {1'b0, cfg_i.start_col} : walk_col_q;

  assign addr_sum = {1'b0, prod_q} + (PROD_W + 1)'(col_src);

  tmwf_ram #(
    .WIDTH (WALL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (idx_q),
    .wdata_i (mask_q),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_sum[STORE_AW-1:0]),
    .rdata_o (walls)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_i;
      idx_q  <= cell_index_i;
      mask_q <= wall_mask_i;
    end
    if (cmd_i.mul) begin
      prod_q <= {{DIM_W{1'b0}}, row_src} * {{DIM_W{1'b0}}, cols};
    end
    if (cmd_i.eval) begin
      row_res_q  <= row_res_d;
      col_res_q  <= col_res_d;
      exit_res_q <= exit_res_d;
      stat_res_q <= stat_res_d;
    end
  end

  // start and step evaluation
  always_comb begin
    start_in   = ({1'b0, cfg_i.start_row} < rows) && ({1'b0, cfg_i.start_col} < cols);
    entry      = start_in ? pick_entry({1'b0, cfg_i.start_row}, {1'b0, cfg_i.start_col},
                                       rows, cols, walls, lh) : SIDE_NONE;
    up         = walk_row_q[0] ^ walk_col_q[0];
    b1         = ((walls & held_q) != '0) ? turn_side(held_q, up, lh) : held_q;
    b2         = ((walls & b1) != '0) ? turn_side(b1, up, lh) : b1;
    nxt_row    = {1'b0, walk_row_q};
    nxt_col    = {1'b0, walk_col_q};
    if (b2 == SIDE_LEFT) begin
      nxt_col = {1'b0, walk_col_q} - (DIM_W + 1)'(1);
    end else if (b2 == SIDE_RIGHT) begin
      nxt_col = {1'b0, walk_col_q} + (DIM_W + 1)'(1);
    end else if (up) begin
      nxt_row = {1'b0, walk_row_q} + (DIM_W + 1)'(1);
    end else begin
      nxt_row = {1'b0, walk_row_q} - (DIM_W + 1)'(1);
    end
    // off the grid on either axis, a move below zero wraps above any size
    leaves     = (nxt_row >= {1'b0, rows}) || (nxt_col >= {1'b0, cols});

    walk_row_d = walk_row_q;
    walk_col_d = walk_col_q;
    held_d     = held_q;
    walking_d  = walking_q;
    row_res_d  = '0;
    col_res_d  = '0;
    exit_res_d = 1'b0;
    stat_res_d = ST_IDLE;

    if (op_q == OP_START) begin
      row_res_d = cfg_i.start_row;
      col_res_d = cfg_i.start_col;
      if (entry == SIDE_NONE) begin
        walking_d  = 1'b0;
        stat_res_d = ST_BLOCKED;
      end else begin
        walk_row_d = {1'b0, cfg_i.start_row};
        walk_col_d = {1'b0, cfg_i.start_col};
        held_d     = entry;
        walking_d  = 1'b1;
        stat_res_d = ST_OK;
      end
    end else if (walking_q) begin
      row_res_d = walk_row_q[POS_W-1:0];
      col_res_d = walk_col_q[POS_W-1:0];
      if (walls == WALLS_ALL) begin
        stat_res_d = ST_ENCLOSED;
        walking_d  = 1'b0;
      end else begin
        stat_res_d = ST_OK;
        held_d     = b2;
        if (leaves) begin
          exit_res_d = 1'b1;
          walking_d  = 1'b0;
        end else begin
          walk_row_d = nxt_row[DIM_W-1:0];
          walk_col_d = nxt_col[DIM_W-1:0];
          held_d     = side_on_entry(b2, nxt_row[0] ^ nxt_col[0], lh);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_row_q <= '0;
      walk_col_q <= '0;
      held_q     <= SIDE_LEFT;
      walking_q  <= 1'b0;
    end else if (cmd_i.eval) begin
      walk_row_q <= walk_row_d;
      walk_col_q <= walk_col_d;
      held_q     <= held_d;
      walking_q  <= walking_d;
    end
  end

  assign stat_o.op  = op_q;
  assign cell_row_o = row_res_q;
  assign cell_col_o = col_res_q;
  assign exited_o   = exit_res_q;
  assign status_o   = stat_res_q;

endmodule

`default_nettype wire

// ===== design/triangle_maze_wall_follower_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_maze_wall_follower_unit
// wall follower over a grid of triangular cells with a 4096-entry wall store
// ----------------------------------------------------------------------------
// sequence: a start or step beat is captured, then passes the multiply, store read
//   and evaluate states; evaluate waits while a pending result is stalled at the output
// input: a new beat is stalled until the last one has finished, a write after its multiply
// reset: walk state idle, held side left, registers at rows 1 cols 1 start 0,0
//   right-hand rule; wall store contents undefined until written, no clear pass
`timescale 1ns / 1ps
`default_nettype none

module triangle_maze_wall_follower_unit import tmwf_pkg::*; #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            op_i,
  input  wire logic [STORE_AW-1:0]   cell_index_i,
  input  wire logic [WALL_W-1:0]     wall_mask_i,
  // result channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic      [POS_W-1:0]      cell_row_o,
  output logic      [POS_W-1:0]      cell_col_o,
  output logic                       exited_o,
  output logic      [1:0]            status_o
);

  cfg_t  cfg_q;
  cmd_t  cmd;
  stat_t stat;

  // register file; the user must write it only while no beat is in flight, not enforced here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.maze_rows <= DIM_W'(1);
      cfg_q.maze_cols <= DIM_W'(1);
      cfg_q.start_row <= '0;
      cfg_q.start_col <= '0;
      cfg_q.hand_rule <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAZE_ROWS: cfg_q.maze_rows <= cfg_wdata_i[DIM_W-1:0];
        CFG_MAZE_COLS: cfg_q.maze_cols <= cfg_wdata_i[DIM_W-1:0];
        CFG_START_ROW: cfg_q.start_row <= cfg_wdata_i[POS_W-1:0];
        CFG_START_COL: cfg_q.start_col <= cfg_wdata_i[POS_W-1:0];
        CFG_HAND_RULE: cfg_q.hand_rule <= cfg_wdata_i[0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // sequencer: idle -> multiply -> read -> evaluate, a write returns to idle after multiply
  tmwf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // store, walk state and result register
  tmwf_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (op_i),
    .cell_index_i (cell_index_i),
    .wall_mask_i  (wall_mask_i),
    .cell_row_o   (cell_row_o),
    .cell_col_o   (cell_col_o),
    .exited_o     (exited_o),
    .status_o     (status_o)
  );

  // an accepted beat blocks the input until its sequence completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting a beat");

  // a pending result is never overwritten by a new evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  // every evaluation presents a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.eval |=> out_valid_o)
    else $error("evaluation did not produce a result");

  // at most one of capture, multiply, read and evaluate at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.mul, cmd.rd, cmd.eval}))
    else $error("overlapping sequencer commands");

endmodule

`default_nettype wire
